FILE: rtl/bssc_pkg.sv
// Shared constants, codes, handshake structs and the gate table for the commutation controller.
package bssc_pkg;

   localparam int SpeedWidth  = 10;
   localparam int PeriodWidth = 14;
   localparam int PhaseWidth  = 3;
   localparam int ModeWidth   = 3;
   localparam int CmdWidth    = 3;
   localparam int GateWidth   = 6;
   localparam int DivSteps    = 14;
   localparam int ReqDataWidth = 16;
   localparam int RspDataWidth = 40;

   localparam logic [SpeedWidth-1:0]  MAX_SPEED  = 10'd1000;
   localparam logic [PeriodWidth-1:0] PERIOD_NUM = 14'd10000;
   localparam logic [PhaseWidth-1:0]  LAST_PHASE = 3'd5;

   // control mode codes, as seen on mode_out
   localparam logic [ModeWidth-1:0] MODE_INIT      = 3'd0;
   localparam logic [ModeWidth-1:0] MODE_READY     = 3'd1;
   localparam logic [ModeWidth-1:0] MODE_ROTATING  = 3'd2;
   localparam logic [ModeWidth-1:0] MODE_STOPPED   = 3'd3;
   localparam logic [ModeWidth-1:0] MODE_REVERSING = 3'd4;

   // operator commands
   localparam logic [CmdWidth-1:0] CMD_NONE  = 3'd0;
   localparam logic [CmdWidth-1:0] CMD_START = 3'd1;
   localparam logic [CmdWidth-1:0] CMD_STOP  = 3'd2;
   localparam logic [CmdWidth-1:0] CMD_SPEED = 3'd3;
   localparam logic [CmdWidth-1:0] CMD_DIR   = 3'd4;

   typedef struct packed {
      logic accept;
      logic load_out;
   } ctrl_cmd_type;

   typedef struct packed {
      logic need_div;
      logic div_done;
   } dp_status_type;

   function automatic logic [GateWidth-1:0] gate_bits(input logic [PhaseWidth-1:0] phase);
      logic [GateWidth-1:0] bits;
      case (phase)
         3'd0:    bits = 6'b100001;
         3'd1:    bits = 6'b000011;
         3'd2:    bits = 6'b000110;
         3'd3:    bits = 6'b001100;
         3'd4:    bits = 6'b011000;
         3'd5:    bits = 6'b110000;
         default: bits = '0;
      endcase
      return bits;
   endfunction

endpackage

FILE: rtl/bldc_six_step_commutation_control.sv
// Six-step commutation controller: a millisecond tick or a plain control step goes from
// acceptance through the finish state to the result word; a control step that reloads the step
// period also waits in the divide state for the bit-serial divider. One word is in work at a time;
// a finished result may wait in the output register while the next word is taken. Reset is
// synchronous and clears all motor state.
module bldc_six_step_commutation_control
   import bssc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [ReqDataWidth-1:0] req_tdata,  // fault_in, cmd[2:0], speed_value[9:0], direction_value
   input  logic                    req_tuser,  // func: 0 control step, 1 millisecond tick
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [RspDataWidth-1:0] rsp_tdata   // gate_pattern[5:0], phase_out[2:0], speed_out[9:0],
                                               // direction_out, running_out, fault_out,
                                               // mode_out[2:0], period_out[13:0]
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   bssc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   bssc_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .status   (status),
      .req_func (req_tuser),
      .req_data (req_tdata),
      .rsp_data (rsp_tdata)
   );

endmodule

FILE: rtl/bssc_div.sv
// Iterative restoring divider: step period = 10000 / speed, one quotient bit per cycle.
module bssc_div
   import bssc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [SpeedWidth-1:0]  divisor,
   output logic                   done,
   output logic [PeriodWidth-1:0] quotient
);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [3:0]             cnt_ff, cnt_in;
   logic [SpeedWidth-1:0]  rem_ff, rem_in;
   logic [SpeedWidth-1:0]  dvs_ff, dvs_in;
   logic [PeriodWidth-1:0] quo_ff, quo_in;
   logic [SpeedWidth:0]    trial;
   logic                   fits;

   // remainder stays below the divisor, so it fits in the divisor width
   assign trial = {rem_ff, PERIOD_NUM[cnt_ff]};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 4'(DivSteps - 1);
         rem_in  = '0;
         quo_in  = '0;
         dvs_in  = (divisor == '0) ? SpeedWidth'(1) : divisor;
      end else if (busy_ff) begin
         rem_in = fits ? SpeedWidth'(trial - {1'b0, dvs_ff}) : trial[SpeedWidth-1:0];
         quo_in = {quo_ff[PeriodWidth-2:0], fits};
         cnt_in = cnt_ff - 4'd1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("divider done without a running division");

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !start)
      else $error("divider started while busy");

endmodule

FILE: rtl/bssc_datapath.sv
// Motor state registers, command and state-machine update, tick handling and result word.
module bssc_datapath
   import bssc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  ctrl_cmd_type            cmd,
   output dp_status_type           status,
   input  logic                    req_func,
   input  logic [ReqDataWidth-1:0] req_data,
   output logic [RspDataWidth-1:0] rsp_data
);

   logic [ModeWidth-1:0]   mode_ff, mode_in;
   logic [PhaseWidth-1:0]  phase_ff, phase_in;
   logic                   cur_dir_ff, cur_dir_in;
   logic                   want_dir_ff, want_dir_in;
   logic [SpeedWidth-1:0]  cur_speed_ff, cur_speed_in;
   logic [SpeedWidth-1:0]  want_speed_ff, want_speed_in;
   logic                   started_ff, started_in;
   logic                   fault_ff, fault_in;
   logic [PeriodWidth-1:0] period_ff, period_in;
   logic [PeriodWidth-1:0] countdown_ff, countdown_in;
   logic [SpeedWidth-1:0]  saved_speed_ff, saved_speed_in;
   logic                   rev_ff, rev_in;
   logic [RspDataWidth-1:0] rsp_data_ff, rsp_data_in;

   logic                  f_fault;
   logic [CmdWidth-1:0]   f_cmd;
   logic [SpeedWidth-1:0] f_speed;
   logic                  f_dir;
   logic [SpeedWidth-1:0] spd;

   // control-step results
   logic [ModeWidth-1:0]  c_mode;
   logic [PhaseWidth-1:0] c_phase;
   logic                  c_cur_dir, c_want_dir, c_started, c_fault, c_rev, c_need_div;
   logic [SpeedWidth-1:0] c_cur_speed, c_want_speed, c_saved;

   logic                  div_done;
   logic [PeriodWidth-1:0] quotient;

   assign f_fault = req_data[0];
   assign f_cmd   = req_data[3:1];
   assign f_speed = req_data[13:4];
   assign f_dir   = req_data[14];
   assign spd     = (f_speed > MAX_SPEED) ? MAX_SPEED : f_speed;

   always_comb begin
      c_mode       = mode_ff;
      c_phase      = phase_ff;
      c_cur_dir    = cur_dir_ff;
      c_want_dir   = want_dir_ff;
      c_cur_speed  = cur_speed_ff;
      c_want_speed = want_speed_ff;
      c_started    = started_ff;
      c_fault      = fault_ff;
      c_saved      = saved_speed_ff;
      c_rev        = rev_ff;
      c_need_div   = 1'b0;

      if (f_fault) begin
         c_fault = 1'b1;
         c_mode  = MODE_STOPPED;
      end

      case (f_cmd)
         CMD_START: begin
            if (c_want_speed == '0) c_want_speed = spd;
            if (c_want_speed != '0) c_started = 1'b1;
         end
         CMD_STOP: begin
            c_started = 1'b0;
            c_fault   = 1'b0;
         end
         CMD_SPEED: c_want_speed = spd;
         CMD_DIR:   c_want_dir = f_dir;
         default: ;
      endcase

      case (c_mode)
         MODE_INIT: begin
            c_phase      = '0;
            c_cur_dir    = 1'b0;
            c_cur_speed  = '0;
            c_want_dir   = 1'b0;
            c_want_speed = '0;
            c_started    = 1'b0;
            c_fault      = 1'b0;
            c_mode       = MODE_READY;
         end
         MODE_READY: begin
            if (c_want_dir != c_cur_dir) begin
               if (!c_rev) begin
                  c_saved = c_want_speed;
                  c_rev   = 1'b1;
               end
               c_mode = MODE_REVERSING;
            end else if (c_want_speed != '0 && c_started && !c_fault) begin
               // period reload goes through the divider
               c_need_div = 1'b1;
               c_mode     = MODE_ROTATING;
            end else begin
               c_cur_speed = '0;
            end
         end
         MODE_ROTATING: begin
            if (!c_started || c_fault) c_cur_speed = '0;
            // after a ramp step the mode is ready, unless the direction check below selects reversing
            if (c_cur_speed < c_want_speed) begin
               c_cur_speed = c_cur_speed + SpeedWidth'(1);
               c_mode      = MODE_READY;
            end else if (c_cur_speed > c_want_speed) begin
               c_cur_speed = c_cur_speed - SpeedWidth'(1);
               c_mode      = MODE_READY;
            end
            if (c_want_dir != c_cur_dir) begin
               if (!c_rev) begin
                  c_saved = c_want_speed;
                  c_rev   = 1'b1;
               end
               c_mode = MODE_REVERSING;
            end
         end
         MODE_STOPPED: begin
            c_started    = 1'b0;
            c_want_speed = '0;
            c_cur_speed  = '0;
            c_mode       = MODE_READY;
         end
         MODE_REVERSING: begin
            if (c_cur_speed != '0) begin
               c_want_speed = '0;
            end else begin
               c_cur_dir    = c_want_dir;
               c_want_speed = c_saved;
               c_phase      = '0;
               c_started    = 1'b1;
               c_rev        = 1'b0;
            end
            c_mode = MODE_ROTATING;
         end
         default: ;
      endcase
   end

   always_comb begin
      mode_in        = mode_ff;
      phase_in       = phase_ff;
      cur_dir_in     = cur_dir_ff;
      want_dir_in    = want_dir_ff;
      cur_speed_in   = cur_speed_ff;
      want_speed_in  = want_speed_ff;
      started_in     = started_ff;
      fault_in       = fault_ff;
      period_in      = period_ff;
      countdown_in   = countdown_ff;
      saved_speed_in = saved_speed_ff;
      rev_in         = rev_ff;

      if (cmd.accept && req_func) begin
         if (countdown_ff != '0) begin
            countdown_in = countdown_ff - PeriodWidth'(1);
         end else begin
            if (cur_dir_ff)
               phase_in = (phase_ff >= LAST_PHASE) ? '0 : phase_ff + PhaseWidth'(1);
            else
               phase_in = (phase_ff == '0 || phase_ff > LAST_PHASE) ? LAST_PHASE
                          : phase_ff - PhaseWidth'(1);
            countdown_in = period_ff;
         end
      end else if (cmd.accept) begin
         mode_in        = c_mode;
         phase_in       = c_phase;
         cur_dir_in     = c_cur_dir;
         want_dir_in    = c_want_dir;
         cur_speed_in   = c_cur_speed;
         want_speed_in  = c_want_speed;
         started_in     = c_started;
         fault_in       = c_fault;
         saved_speed_in = c_saved;
         rev_in         = c_rev;
      end

      if (div_done) begin
         period_in    = quotient;
         countdown_in = quotient;
      end
   end

   bssc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.accept && !req_func && c_need_div),
      .divisor  (c_cur_speed),
      .done     (div_done),
      .quotient (quotient)
   );

   assign status.need_div = !req_func && c_need_div;
   assign status.div_done = div_done;

   // result word, highest field first
   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (cmd.load_out)
         rsp_data_in = {1'b0, period_ff, mode_ff, fault_ff, started_ff, cur_dir_ff,
                        cur_speed_ff, phase_ff,
                        (cur_speed_ff == '0) ? GateWidth'(0) : gate_bits(phase_ff)};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_INIT;
         phase_ff       <= '0;
         cur_dir_ff     <= 1'b0;
         want_dir_ff    <= 1'b0;
         cur_speed_ff   <= '0;
         want_speed_ff  <= '0;
         started_ff     <= 1'b0;
         fault_ff       <= 1'b0;
         period_ff      <= '0;
         countdown_ff   <= '0;
         saved_speed_ff <= '0;
         rev_ff         <= 1'b0;
      end else begin
         mode_ff        <= mode_in;
         phase_ff       <= phase_in;
         cur_dir_ff     <= cur_dir_in;
         want_dir_ff    <= want_dir_in;
         cur_speed_ff   <= cur_speed_in;
         want_speed_ff  <= want_speed_in;
         started_ff     <= started_in;
         fault_ff       <= fault_in;
         period_ff      <= period_in;
         countdown_ff   <= countdown_in;
         saved_speed_ff <= saved_speed_in;
         rev_ff         <= rev_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_data = rsp_data_ff;

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff <= LAST_PHASE)
      else $error("commutation phase out of range");

   a_speed_limit: assert property (@(posedge clock) disable iff (reset)
      cur_speed_ff <= MAX_SPEED && want_speed_ff <= MAX_SPEED)
      else $error("speed above limit");

endmodule

FILE: rtl/bssc_ctrl.sv
// Sequencer: accepts a word, waits for the divider when needed, hands the result to the output register.
module bssc_ctrl
   import bssc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_DIV    = 3'b010,
      ST_FINISH = 3'b100
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;

   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign req_tready   = (state_ff == ST_IDLE);
   assign cmd.accept   = (state_ff == ST_IDLE) && req_tvalid;
   assign cmd.load_out = (state_ff == ST_FINISH) && out_free;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_tvalid) state_in = status.need_div ? ST_DIV : ST_FINISH;
         ST_DIV:    if (status.div_done) state_in = ST_FINISH;
         ST_FINISH: if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out)
         rsp_valid_in = 1'b1;
      else if (rsp_tready)
         rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      status.div_done |-> state_ff == ST_DIV)
      else $error("divider finished outside the divide state");

   a_div_follows: assert property (@(posedge clock) disable iff (reset)
      cmd.accept && status.need_div |=> state_ff == ST_DIV)
      else $error("period reload skipped the divider");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp_valid_ff)
      else $error("result word not presented after load");

endmodule
